[rtl/display_command_deframer_top_defines.svh]
// Assertion macros for the display command deframer.
// Included by the top level; expects clk and arst_n in scope.
`ifndef DISPLAY_COMMAND_DEFRAMER_TOP_DEFINES_SVH
`define DISPLAY_COMMAND_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/dcd_pkg.sv]
// Shared types and constants of the display command deframer.
// No dependencies.
package dcd_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned FIELD_W     = 16;
	localparam int unsigned COUNT_W     = 20;
	localparam int unsigned INDEX_W     = 4;
	localparam int unsigned FIELD_BYTES = 10;
	localparam int unsigned OUT_DEPTH   = 3;

	localparam logic [BYTE_W-1:0]  BITMAP_START_TYPE  = 8'd99;
	localparam logic [COUNT_W-1:0] BITMAP_BYTES_RESET = 20'd153600;
	localparam logic [INDEX_W-1:0] FINAL_INDEX        = 4'd10;

	typedef enum logic [1:0] {
		EV_NONE         = 2'd0,
		EV_CMD          = 2'd1,
		EV_BITMAP_START = 2'd2,
		EV_PIXEL        = 2'd3
	} event_kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
	} dcd_in_t;

	typedef struct packed {
		event_kind_t        event_kind;
		logic [BYTE_W-1:0]  cmd_type;
		logic [FIELD_W-1:0] x_start;
		logic [FIELD_W-1:0] y_start;
		logic [FIELD_W-1:0] rect_width;
		logic [FIELD_W-1:0] rect_height;
		logic [FIELD_W-1:0] fill_color;
		logic [BYTE_W-1:0]  pixel_byte;
		logic               last_pixel;
		logic               reply_buttons;
	} dcd_out_t;

	typedef logic [COUNT_W-1:0] dcd_cfg_t;

endpackage

[rtl/dcd_chan_if.sv]
// Valid/ready channel carrying one payload of type T per request.
// Uses no package; payload types come from dcd_pkg at instantiation.
interface dcd_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/dcd_core.sv]
// Frame state and result formation for one registered byte.
// Depends on dcd_pkg.
module dcd_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_s1,
	input  logic [dcd_pkg::BYTE_W-1:0]     byte_s1,
	input  logic                           cfg_wr,
	input  logic [dcd_pkg::COUNT_W-1:0]    cfg_data,
	output dcd_pkg::dcd_out_t              result
);

	logic [dcd_pkg::COUNT_W-1:0] bitmap_bytes_q;
	logic [dcd_pkg::INDEX_W-1:0] byte_index_q;
	logic [dcd_pkg::BYTE_W-1:0]  type_q;
	logic [dcd_pkg::BYTE_W-1:0]  field_bytes_q [dcd_pkg::FIELD_BYTES];
	logic                        bitmap_mode_q;
	logic [dcd_pkg::COUNT_W-1:0] pixel_count_q;
	logic                        reply_toggle_q;

	logic [dcd_pkg::COUNT_W-1:0] count_inc;
	logic                        bitmap_done;
	logic                        frame_start;
	logic                        cmd_done;
	logic [dcd_pkg::INDEX_W-1:0] field_sel;

	assign count_inc   = pixel_count_q + 1'b1;
	assign bitmap_done = count_inc == bitmap_bytes_q;
	assign frame_start = (byte_index_q == '0) || (byte_index_q > dcd_pkg::FINAL_INDEX);
	assign cmd_done    = byte_index_q == dcd_pkg::FINAL_INDEX;
	assign field_sel   = byte_index_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_bytes_q <= dcd_pkg::BITMAP_BYTES_RESET;
		end else if (cfg_wr) begin
			bitmap_bytes_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q   <= '0;
			type_q         <= '0;
			bitmap_mode_q  <= 1'b0;
			pixel_count_q  <= '0;
			reply_toggle_q <= 1'b0;
		end else if (valid_s1) begin
			if (bitmap_mode_q) begin
				if (bitmap_done) begin
					bitmap_mode_q  <= 1'b0;
					pixel_count_q  <= '0;
					reply_toggle_q <= ~reply_toggle_q;
				end else begin
					pixel_count_q <= count_inc;
				end
			end else if (frame_start) begin
				type_q <= byte_s1;
				if (byte_s1 == dcd_pkg::BITMAP_START_TYPE) begin
					bitmap_mode_q <= 1'b1;
					pixel_count_q <= '0;
					byte_index_q  <= '0;
				end else begin
					byte_index_q <= 4'd1;
				end
			end else if (cmd_done) begin
				byte_index_q <= '0;
			end else begin
				byte_index_q <= byte_index_q + 1'b1;
			end
		end
	end

	// Bytes of a frame are always written in order before the frame completes.
	always_ff @(posedge clk) begin
		if (valid_s1 && !bitmap_mode_q && !frame_start) begin
			field_bytes_q[field_sel] <= byte_s1;
		end
	end

	always_comb begin
		result = '0;
		if (bitmap_mode_q) begin
			result.event_kind = dcd_pkg::EV_PIXEL;
			result.pixel_byte = byte_s1;
			result.last_pixel = bitmap_done;
		end else if (frame_start) begin
			if (byte_s1 == dcd_pkg::BITMAP_START_TYPE) begin
				result.event_kind = dcd_pkg::EV_BITMAP_START;
			end
		end else if (cmd_done) begin
			result.event_kind    = dcd_pkg::EV_CMD;
			result.cmd_type      = type_q;
			result.x_start       = {field_bytes_q[1], field_bytes_q[0]};
			result.y_start       = {field_bytes_q[3], field_bytes_q[2]};
			result.rect_width    = {field_bytes_q[5], field_bytes_q[4]};
			result.rect_height   = {field_bytes_q[7], field_bytes_q[6]};
			result.fill_color    = {byte_s1, field_bytes_q[8]};
			result.reply_buttons = reply_toggle_q;
		end
	end

endmodule

[rtl/dcd_out_fifo.sv]
// Three-entry result queue between the core and the result channel.
// Depends on dcd_pkg.
module dcd_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dcd_pkg::dcd_out_t push_data,
	input  logic              pop,
	output logic              not_empty,
	output dcd_pkg::dcd_out_t head,
	output logic [1:0]        count
);

	localparam logic [1:0] LAST_SLOT = 2'(dcd_pkg::OUT_DEPTH - 1);

	dcd_pkg::dcd_out_t entries_q [dcd_pkg::OUT_DEPTH];
	logic [1:0]        wr_ptr_q;
	logic [1:0]        rd_ptr_q;
	logic [1:0]        count_q;

	assign not_empty = count_q != '0;
	assign head      = entries_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? 2'd0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? 2'd0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/display_command_deframer_top.sv]
// Display command deframer: one received byte in, one event out per request.
// Path: an accepted byte is held in the input register, then its result enters the result queue.
// Throughput: one byte per cycle; rx.ready looks only at the input register and the
// three-entry result queue, so a stalled res side holds three results, then stalls rx.
// Reset: arst_n clears frame state, queue pointers and input valid; bitmap_bytes returns to 153600.
// Depends on dcd_pkg, dcd_chan_if, dcd_core, dcd_out_fifo, the defines header; cfg.ready is high.
`include "display_command_deframer_top_defines.svh"

module display_command_deframer_top (
	input  logic clk,
	input  logic arst_n,
	dcd_chan_if.sink   rx,
	dcd_chan_if.sink   cfg,
	dcd_chan_if.source res
);

	logic                       valid_s1;
	logic [dcd_pkg::BYTE_W-1:0] byte_s1;
	logic                       rx_fire;
	logic [2:0]                 occupancy;
	logic [1:0]                 fifo_count;
	dcd_pkg::dcd_out_t          core_result;

	assign occupancy = {1'b0, fifo_count} + {2'b0, valid_s1};
	assign rx.ready  = occupancy < 3'(dcd_pkg::OUT_DEPTH);
	assign rx_fire   = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rx_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire) begin
			byte_s1 <= rx.data.rx_byte;
		end
	end

	dcd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.cfg_wr   (cfg.valid),
		.cfg_data (cfg.data),
		.result   (core_result)
	);

	dcd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (core_result),
		.pop       (res.valid && res.ready),
		.not_empty (res.valid),
		.head      (res.data),
		.count     (fifo_count)
	);

	`DCD_ASSERT_NOW(a_no_overflow, valid_s1, fifo_count != 2'd3, "result queue overflow")
	`DCD_ASSERT_NEXT(a_accept_reaches_s1, rx_fire, valid_s1, "accepted byte lost")
	`DCD_ASSERT_NOW(a_last_is_pixel, res.valid && res.data.last_pixel, res.data.event_kind == dcd_pkg::EV_PIXEL, "last_pixel outside pixel event")

endmodule
